// ----- rtl/imh_pkg.sv -----
// Shared types, codes and sizes for the indexed min-heap block.
package imh_pkg;

  // Heap and node table sizes.
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned NODE_COUNT = 256;

  // Field widths.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned NODE_W   = $clog2(NODE_COUNT);
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);

  // Operation codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT   = 2'd0,
    KIND_EXTRACT  = 2'd1,
    KIND_DECREASE = 2'd2,
    KIND_QUERY    = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_EMPTY     = 3'd1,
    STATUS_NOT_FOUND = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_DUPLICATE = 3'd4
  } status_e;

  // One heap slot: node number and its priority.
  typedef struct packed {
    logic [NODE_W-1:0]        node;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Write request into the heap slot memory.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } slot_wr_t;

endpackage

// ----- rtl/imh_if.sv -----
// Request and response channel interfaces of the indexed min-heap block.
interface imh_req_if import imh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [NODE_W-1:0]        node_id;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, output kind, output node_id, output priority_req,
                  input ready);
  modport sink (input valid, input kind, input node_id, input priority_req,
                output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        result_node;
  logic signed [PRIO_W-1:0] result_priority;
  logic [STATUS_W-1:0]      status;
  logic                     is_present;
  logic [SLOT_W-1:0]        entry_count;

  modport source (output valid, output result_node, output result_priority,
                  output status, output is_present, output entry_count,
                  input ready);
  modport sink (input valid, input result_node, input result_priority,
                input status, input is_present, input entry_count,
                output ready);
endinterface

// ----- rtl/indexed_min_heap.sv -----
// Indexed binary min-heap with insert, extract-min, decrease-key and query.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+--------------------------------------------------
//  req_i    | in        | kind, node_id, priority_req
//  rsp_o    | out       | result_node, result_priority, status, is_present,
//           |           | entry_count
//
// Insert climbs one heap level per pass and extract-min descends one level per
// pass; decrease-key first reads the node's slot and priority, then climbs like
// insert. The pace is set by the registered read of the heap slot memory and
// the one shared priority compare.
// Reset clears the count and the per-node presence bits at once; no clearing
// pass is needed. A finished response waits in the output register, so a new
// request beat is taken while the previous response is still stalled.
module indexed_min_heap import imh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  imh_req_if.sink  req_i,
  imh_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_TAKE,
    ST_DEC_POS,
    ST_DEC_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [SLOT_W-1:0]        count_q, count_d;
  logic [SLOT_W-1:0]        hole_q, hole_d;
  logic [SLOT_W-1:0]        child_idx_q, child_idx_d;
  entry_t                   child_q, child_d;
  logic [NODE_W-1:0]        item_node_q, item_node_d;
  logic signed [PRIO_W-1:0] item_prio_q, item_prio_d;
  logic [NODE_COUNT-1:0]    pos_valid_q, pos_valid_d;
  logic [NODE_W-1:0]        res_node_q, res_node_d;
  logic signed [PRIO_W-1:0] res_prio_q, res_prio_d;
  status_e                  res_status_q, res_status_d;
  logic                     res_present_q, res_present_d;
  logic                     out_valid_q, out_valid_d;
  logic [NODE_W-1:0]        out_node_q, out_node_d;
  logic signed [PRIO_W-1:0] out_prio_q, out_prio_d;
  status_e                  out_status_q, out_status_d;
  logic                     out_present_q, out_present_d;
  logic [SLOT_W-1:0]        out_count_q, out_count_d;

  // Heap memory ports.
  slot_wr_t          slot_wr;
  logic [ADDR_W-1:0] rd_a_addr;
  logic [ADDR_W-1:0] rd_b_addr;
  entry_t            rd_a;
  entry_t            rd_b;

  // Position table: heap slot of each present node.
  logic [SLOT_W-1:0] pos_mem [NODE_COUNT];
  logic [SLOT_W-1:0] pos_rd_q;
  logic              pos_wr_en;
  logic [NODE_W-1:0] pos_wr_node;
  logic [SLOT_W-1:0] pos_wr_slot;

  // Shared priority comparator.
  logic signed [PRIO_W-1:0] cmp_a;
  logic signed [PRIO_W-1:0] cmp_b;
  logic                     cmp_lt;

  // Left and right child slots of the hole.
  logic [SLOT_W:0] left_idx;
  logic [SLOT_W:0] right_idx;
  logic            accept;

  assign accept    = req_i.valid && req_i.ready;
  assign left_idx  = {hole_q, 1'b0};
  assign right_idx = left_idx + 1'b1;

  imh_slot_ram u_slot_ram (
    .clk_i       (clk_i),
    .wr_i        (slot_wr),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_o      (rd_a),
    .rd_b_o      (rd_b)
  );

  // Position table write and registered read at the requested node.
  always_ff @(posedge clk_i) begin
    if (pos_wr_en) begin
      pos_mem[pos_wr_node] <= pos_wr_slot;
    end
    pos_rd_q <= pos_mem[req_i.node_id];
  end

  // Read addresses: while idle, the root and the last slot are fetched.
  always_comb begin
    rd_a_addr = '0;
    rd_b_addr = ADDR_W'(count_q - 1'b1);
    unique case (state_q)
      ST_DEC_POS: rd_a_addr = ADDR_W'(pos_rd_q - 1'b1);
      ST_UP_RD:   rd_a_addr = ADDR_W'((hole_q >> 1) - 1'b1);
      ST_DN_RD: begin
        rd_a_addr = ADDR_W'(left_idx - 1'b1);
        rd_b_addr = ADDR_W'(left_idx);
      end
      default: ;
    endcase
  end

  // Operand selection for the one comparator.
  always_comb begin
    cmp_a = item_prio_q;
    cmp_b = rd_a.prio;
    unique case (state_q)
      ST_DN_SEL: begin
        cmp_a = rd_b.prio;
        cmp_b = rd_a.prio;
      end
      ST_DN_CMP: begin
        cmp_a = child_q.prio;
        cmp_b = item_prio_q;
      end
      default: ;
    endcase
  end

  assign cmp_lt = cmp_a < cmp_b;

  // Sequencer: next state, heap and position writes.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    hole_d        = hole_q;
    child_idx_d   = child_idx_q;
    child_d       = child_q;
    item_node_d   = item_node_q;
    item_prio_d   = item_prio_q;
    pos_valid_d   = pos_valid_q;
    res_node_d    = res_node_q;
    res_prio_d    = res_prio_q;
    res_status_d  = res_status_q;
    res_present_d = res_present_q;
    out_valid_d   = out_valid_q;
    out_node_d    = out_node_q;
    out_prio_d    = out_prio_q;
    out_status_d  = out_status_q;
    out_present_d = out_present_q;
    out_count_d   = out_count_q;
    slot_wr.en    = 1'b0;
    slot_wr.addr  = ADDR_W'(hole_q - 1'b1);
    slot_wr.data  = '{node: item_node_q, prio: item_prio_q};
    pos_wr_en     = 1'b0;
    pos_wr_node   = item_node_q;
    pos_wr_slot   = hole_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_node_d   = req_i.node_id;
          item_prio_d   = req_i.priority_req;
          res_node_d    = '0;
          res_prio_d    = '0;
          res_status_d  = STATUS_OK;
          res_present_d = 1'b0;
          state_d       = ST_DONE;
          unique case (kind_e'(req_i.kind))
            KIND_INSERT: begin
              if (pos_valid_q[req_i.node_id]) begin
                res_status_d = STATUS_DUPLICATE;
              end else if (count_q == SLOT_W'(CAPACITY)) begin
                res_status_d = STATUS_FULL;
              end else begin
                count_d = count_q + 1'b1;
                hole_d  = count_q + 1'b1;
                state_d = ST_UP_RD;
              end
            end
            KIND_EXTRACT: begin
              if (count_q == '0) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                state_d = ST_EX_TAKE;
              end
            end
            KIND_DECREASE: begin
              if (!pos_valid_q[req_i.node_id]) begin
                res_status_d = STATUS_NOT_FOUND;
              end else begin
                state_d = ST_DEC_POS;
              end
            end
            KIND_QUERY: begin
              res_present_d = pos_valid_q[req_i.node_id];
            end
            default: ;
          endcase
        end
      end

      // Root and last entry are in; the last one becomes the sift-down item.
      ST_EX_TAKE: begin
        res_node_d              = rd_a.node;
        res_prio_d              = rd_a.prio;
        pos_valid_d[rd_a.node]  = 1'b0;
        if (count_q > SLOT_W'(1)) begin
          item_node_d = rd_b.node;
          item_prio_d = rd_b.prio;
          count_d     = count_q - 1'b1;
          hole_d      = SLOT_W'(1);
          state_d     = ST_DN_RD;
        end else begin
          count_d = '0;
          state_d = ST_DONE;
        end
      end

      // The node's slot is known; its current priority is being read.
      ST_DEC_POS: begin
        hole_d  = pos_rd_q;
        state_d = ST_DEC_CMP;
      end

      // Only a strictly smaller priority moves the node.
      ST_DEC_CMP: begin
        state_d = cmp_lt ? ST_UP_RD : ST_DONE;
      end

      // At the root the item settles; otherwise the parent is fetched.
      ST_UP_RD: begin
        if (hole_q == SLOT_W'(1)) begin
          slot_wr.en                = 1'b1;
          pos_wr_en                 = 1'b1;
          pos_valid_d[item_node_q]  = 1'b1;
          state_d                   = ST_DONE;
        end else begin
          state_d = ST_UP_CMP;
        end
      end

      // A larger parent drops into the hole and the hole climbs.
      ST_UP_CMP: begin
        slot_wr.en = 1'b1;
        pos_wr_en  = 1'b1;
        if (cmp_lt) begin
          slot_wr.data = rd_a;
          pos_wr_node  = rd_a.node;
          hole_d       = hole_q >> 1;
          state_d      = ST_UP_RD;
        end else begin
          pos_valid_d[item_node_q] = 1'b1;
          state_d                  = ST_DONE;
        end
      end

      // Without children the item settles; otherwise both are fetched.
      ST_DN_RD: begin
        if (left_idx > {1'b0, count_q}) begin
          slot_wr.en               = 1'b1;
          pos_wr_en                = 1'b1;
          pos_valid_d[item_node_q] = 1'b1;
          state_d                  = ST_DONE;
        end else begin
          state_d = ST_DN_SEL;
        end
      end

      // The right child wins only when it exists and is strictly smaller.
      ST_DN_SEL: begin
        if (right_idx <= {1'b0, count_q} && cmp_lt) begin
          child_d     = rd_b;
          child_idx_d = SLOT_W'(right_idx);
        end else begin
          child_d     = rd_a;
          child_idx_d = SLOT_W'(left_idx);
        end
        state_d = ST_DN_CMP;
      end

      // A strictly smaller child rises into the hole and the hole descends.
      ST_DN_CMP: begin
        slot_wr.en = 1'b1;
        pos_wr_en  = 1'b1;
        if (cmp_lt) begin
          slot_wr.data = child_q;
          pos_wr_node  = child_q.node;
          hole_d       = child_idx_q;
          state_d      = ST_DN_RD;
        end else begin
          pos_valid_d[item_node_q] = 1'b1;
          state_d                  = ST_DONE;
        end
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_node_d    = res_node_q;
          out_prio_d    = res_prio_q;
          out_status_d  = res_status_q;
          out_present_d = res_present_q;
          out_count_d   = count_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      hole_q        <= '0;
      child_idx_q   <= '0;
      child_q       <= '0;
      item_node_q   <= '0;
      item_prio_q   <= '0;
      pos_valid_q   <= '0;
      res_node_q    <= '0;
      res_prio_q    <= '0;
      res_status_q  <= STATUS_OK;
      res_present_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_node_q    <= '0;
      out_prio_q    <= '0;
      out_status_q  <= STATUS_OK;
      out_present_q <= 1'b0;
      out_count_q   <= '0;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      hole_q        <= hole_d;
      child_idx_q   <= child_idx_d;
      child_q       <= child_d;
      item_node_q   <= item_node_d;
      item_prio_q   <= item_prio_d;
      pos_valid_q   <= pos_valid_d;
      res_node_q    <= res_node_d;
      res_prio_q    <= res_prio_d;
      res_status_q  <= res_status_d;
      res_present_q <= res_present_d;
      out_valid_q   <= out_valid_d;
      out_node_q    <= out_node_d;
      out_prio_q    <= out_prio_d;
      out_status_q  <= out_status_d;
      out_present_q <= out_present_d;
      out_count_q   <= out_count_d;
    end
  end

  // Channel outputs.
  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.result_node     = out_node_q;
  assign rsp_o.result_priority = out_prio_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.is_present      = out_present_q;
  assign rsp_o.entry_count     = out_count_q;

`ifndef SYNTHESIS
  // Between operations, every present node is counted exactly once.
  a_count_matches_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(pos_valid_q) == count_q)
    else $error("heap count differs from the number of present nodes");

  // The heap never grows past its capacity.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOT_W'(CAPACITY))
    else $error("heap count exceeds capacity");

  // An empty report only comes from an empty heap.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && res_status_q == STATUS_EMPTY) |-> count_q == '0)
    else $error("empty status with entries in the heap");

  // A new response beat is only raised when an operation finishes.
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response raised outside the finishing state");
`endif

endmodule

// ----- rtl/imh_slot_ram.sv -----
// Heap slot memory: one write port and two registered read ports.
module imh_slot_ram import imh_pkg::*; (
  input  logic              clk_i,
  input  slot_wr_t          wr_i,
  input  logic [ADDR_W-1:0] rd_a_addr_i,
  input  logic [ADDR_W-1:0] rd_b_addr_i,
  output entry_t            rd_a_o,
  output entry_t            rd_b_o
);

  entry_t mem [CAPACITY];
  entry_t rd_a_q;
  entry_t rd_b_q;

  // Slot i of the heap lives at address i - 1; reads return the old data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

// ----- bench/indexed_min_heap_tb.sv -----
// Self-checking testbench for the indexed min-heap: directed table, then random phases.
module indexed_min_heap_tb import imh_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_GAP       = 8;
  localparam longint      PRIO_FLOOR    = -64'sd2147483648;

  // Random phases: mixed traffic, fill to capacity, drain to empty.
  typedef enum int {
    PHASE_MIX,
    PHASE_FILL,
    PHASE_DRAIN
  } phase_e;

  // One response beat as the heap should produce it.
  typedef struct packed {
    logic [NODE_W-1:0]        node;
    logic signed [PRIO_W-1:0] prio;
    status_e                  status;
    logic                     present;
    logic [SLOT_W-1:0]        count;
  } heap_rsp_t;

  // One row of the directed table.
  typedef struct packed {
    kind_e                    kind;
    logic [NODE_W-1:0]        node;
    logic signed [PRIO_W-1:0] prio;
    logic                     typed;
    heap_rsp_t                want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  bit   no_idle;
  int unsigned error_count;
  int unsigned beat_count;
  int unsigned cycle_count;

  // Shadow heap: slots 1..heap_size, and the slot of each node (0 = absent).
  logic [NODE_W-1:0]        heap_node [1:CAPACITY];
  logic signed [PRIO_W-1:0] heap_prio [1:CAPACITY];
  int unsigned              node_pos  [0:NODE_COUNT-1];
  int unsigned              heap_size;

  heap_rsp_t pending_rsp[$];
  dir_row_t  dir_rows[$];

  imh_req_if req_if ();
  imh_rsp_if rsp_if ();

  indexed_min_heap u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Free-running clock, period 10.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total number of cycles.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("indexed_min_heap test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow heap model
  // ---------------------------------------------------------------------------

  function automatic void heap_place(int unsigned pos, logic [NODE_W-1:0] n,
                                     logic signed [PRIO_W-1:0] p);
    heap_node[pos] = n;
    heap_prio[pos] = p;
    node_pos[n]    = pos;
  endfunction

  // Move the entry at pos toward the root while its parent is strictly larger.
  function automatic void heap_sift_up(int unsigned pos);
    logic [NODE_W-1:0]        n;
    logic signed [PRIO_W-1:0] p;
    n = heap_node[pos];
    p = heap_prio[pos];
    while (pos > 1 && heap_prio[pos / 2] > p) begin
      heap_place(pos, heap_node[pos / 2], heap_prio[pos / 2]);
      pos = pos / 2;
    end
    heap_place(pos, n, p);
  endfunction

  // Move the entry at pos down; the right child wins only when strictly smaller.
  function automatic void heap_sift_down(int unsigned pos);
    logic [NODE_W-1:0]        n;
    logic signed [PRIO_W-1:0] p;
    int unsigned              c;
    n = heap_node[pos];
    p = heap_prio[pos];
    while (2 * pos <= heap_size) begin
      c = 2 * pos;
      if (c + 1 <= heap_size && heap_prio[c + 1] < heap_prio[c]) c++;
      if (heap_prio[c] < p) begin
        heap_place(pos, heap_node[c], heap_prio[c]);
        pos = c;
      end else begin
        break;
      end
    end
    heap_place(pos, n, p);
  endfunction

  // Apply one operation to the shadow heap and return the beat it should produce.
  function automatic heap_rsp_t heap_apply(kind_e k, logic [NODE_W-1:0] n,
                                           logic signed [PRIO_W-1:0] p);
    heap_rsp_t   r;
    int unsigned pos;
    r        = '0;
    r.status = STATUS_OK;
    case (k)
      KIND_INSERT: begin
        if (node_pos[n] != 0) begin
          r.status = STATUS_DUPLICATE;
        end else if (heap_size >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          heap_size++;
          heap_place(heap_size, n, p);
          heap_sift_up(heap_size);
        end
      end
      KIND_EXTRACT: begin
        if (heap_size == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.node = heap_node[1];
          r.prio = heap_prio[1];
          node_pos[r.node] = 0;
          if (heap_size > 1) begin
            heap_place(1, heap_node[heap_size], heap_prio[heap_size]);
            heap_size--;
            heap_sift_down(1);
          end else begin
            heap_size = 0;
          end
        end
      end
      KIND_DECREASE: begin
        pos = node_pos[n];
        if (pos == 0) begin
          r.status = STATUS_NOT_FOUND;
        end else if (p < heap_prio[pos]) begin
          heap_prio[pos] = p;
          heap_sift_up(pos);
        end
      end
      default: begin
        r.present = (node_pos[n] != 0);
      end
    endcase
    r.count = SLOT_W'(heap_size);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic add_row(input kind_e k, input logic [NODE_W-1:0] n,
                         input logic signed [PRIO_W-1:0] p, input logic typed,
                         input logic [NODE_W-1:0] w_node,
                         input logic signed [PRIO_W-1:0] w_prio,
                         input status_e w_status, input logic w_present,
                         input logic [SLOT_W-1:0] w_count);
    dir_row_t row;
    row.kind         = k;
    row.node         = n;
    row.prio         = p;
    row.typed        = typed;
    row.want.node    = w_node;
    row.want.prio    = w_prio;
    row.want.status  = w_status;
    row.want.present = w_present;
    row.want.count   = w_count;
    dir_rows = {dir_rows, row};
  endtask

  // Drive one request beat after a random gap; record its expected response.
  task automatic send_item(input kind_e k, input logic [NODE_W-1:0] n,
                           input logic signed [PRIO_W-1:0] p, input logic typed,
                           input heap_rsp_t want);
    int unsigned gap;
    heap_rsp_t   got;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid        = 1'b1;
    req_if.kind         = k;
    req_if.node_id      = n;
    req_if.priority_req = p;
    do @(posedge clk); while (!req_if.ready);
    got = heap_apply(k, n, p);
    pending_rsp = {pending_rsp, (typed ? want : got)};
  endtask

  // Draw a random request, weighted by phase, with content that reaches deep.
  task automatic gen_item(input phase_e ph, output kind_e k,
                          output logic [NODE_W-1:0] n,
                          output logic signed [PRIO_W-1:0] p);
    int unsigned roll, ins_pct, ext_pct, dec_pct, start, cand;
    longint      lowered;
    case (ph)
      PHASE_FILL:  begin ins_pct = 80; ext_pct = 3;  dec_pct = 12; end
      PHASE_DRAIN: begin ins_pct = 8;  ext_pct = 70; dec_pct = 12; end
      default:     begin ins_pct = 35; ext_pct = 25; dec_pct = 25; end
    endcase
    roll = $urandom_range(0, 99);
    n    = NODE_W'($urandom_range(0, NODE_COUNT - 1));
    // Mostly a narrow band so that ties are common, sometimes the full range.
    if ($urandom_range(0, 9) < 3) p = $urandom;
    else p = int'($urandom_range(0, 64)) - 32;
    if (roll < ins_pct) begin
      k = KIND_INSERT;
      if ($urandom_range(0, 99) < 90) begin
        start = $urandom_range(0, NODE_COUNT - 1);
        for (int j = 0; j < NODE_COUNT; j++) begin
          cand = (start + j) % NODE_COUNT;
          if (node_pos[cand] == 0) begin
            n = NODE_W'(cand);
            break;
          end
        end
      end
    end else if (roll < ins_pct + ext_pct) begin
      k = KIND_EXTRACT;
    end else if (roll < ins_pct + ext_pct + dec_pct) begin
      k = KIND_DECREASE;
      if (heap_size > 0 && $urandom_range(0, 99) < 80) begin
        n = heap_node[$urandom_range(1, heap_size)];
        if ($urandom_range(0, 99) < 70) begin
          lowered = longint'(heap_prio[node_pos[n]]) - longint'($urandom_range(0, 50));
          if (lowered < PRIO_FLOOR) lowered = PRIO_FLOOR;
          p = lowered[PRIO_W-1:0];
        end
      end
    end else begin
      k = KIND_QUERY;
      if (heap_size > 0 && $urandom_range(0, 1) == 1)
        n = heap_node[$urandom_range(1, heap_size)];
    end
  endtask

  // Hold off the sender until every outstanding response beat has arrived.
  task automatic drain_responses();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Run one random phase until its goal has held for a while, or up to an item cap.
  task automatic run_phase(input phase_e ph, input int unsigned min_items);
    int unsigned i, hold;
    kind_e                    k;
    logic [NODE_W-1:0]        n;
    logic signed [PRIO_W-1:0] p;
    i    = 0;
    hold = 0;
    while (!(i >= min_items && hold >= 20) && i < min_items + 800) begin
      if ((ph == PHASE_FILL && heap_size == CAPACITY) ||
          (ph == PHASE_DRAIN && heap_size == 0) || ph == PHASE_MIX) hold++;
      // Stretches of back-to-back traffic on both sides.
      no_idle = (i % 100) < 15;
      gen_item(ph, k, n, p);
      send_item(k, n, p, 1'b0, '0);
      i++;
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Response checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("ERROR: beat %0d: %s", beat_count, msg);
    error_count++;
  endtask

  task automatic check_beat();
    heap_rsp_t want;
    if (pending_rsp.size() == 0) begin
      report_mismatch("response beat with nothing outstanding");
    end else begin
      want = pending_rsp.pop_front();
      if (rsp_if.result_node !== want.node)
        report_mismatch($sformatf("result_node %0d, want %0d", rsp_if.result_node, want.node));
      if (rsp_if.result_priority !== want.prio)
        report_mismatch($sformatf("result_priority %0d, want %0d",
                                  rsp_if.result_priority, want.prio));
      if (rsp_if.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
      if (rsp_if.is_present !== want.present)
        report_mismatch($sformatf("is_present %0d, want %0d", rsp_if.is_present, want.present));
      if (rsp_if.entry_count !== want.count)
        report_mismatch($sformatf("entry_count %0d, want %0d", rsp_if.entry_count, want.count));
    end
    beat_count++;
  endtask

  // Response sink: random stall before each beat, then take it.
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clk);
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready = 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      check_beat();
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    req_if.valid        = 1'b0;
    req_if.kind         = KIND_INSERT;
    req_if.node_id      = '0;
    req_if.priority_req = '0;
    rst_n               = 1'b0;
    no_idle             = 1'b0;
    error_count         = 0;
    beat_count          = 0;
    heap_size           = 0;
    foreach (node_pos[i]) node_pos[i] = 0;

    // Directed table; typed rows are the ones readable without the model.
    add_row(KIND_EXTRACT,  8'd0,   32'sd0,        '1, 8'd0, 32'sd0, STATUS_EMPTY, '0, 9'd0);
    add_row(KIND_QUERY,    8'd0,   32'sd0,        '1, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_DECREASE, 8'd5,   -32'sd7,       '1, 8'd0, 32'sd0, STATUS_NOT_FOUND, '0, 9'd0);
    add_row(KIND_INSERT,   8'd0,   32'sh7FFFFFFF, '1, 8'd0, 32'sd0, STATUS_OK, '0, 9'd1);
    add_row(KIND_INSERT,   8'd255, 32'sh80000000, '1, 8'd0, 32'sd0, STATUS_OK, '0, 9'd2);
    add_row(KIND_INSERT,   8'd0,   32'sd0,        '1, 8'd0, 32'sd0, STATUS_DUPLICATE, '0, 9'd2);
    add_row(KIND_QUERY,    8'd255, 32'sd0,        '1, 8'd0, 32'sd0, STATUS_OK, '1, 9'd2);
    add_row(KIND_QUERY,    8'd254, 32'sh7FFFFFFF, '1, 8'd0, 32'sd0, STATUS_OK, '0, 9'd2);
    add_row(KIND_INSERT,   8'd17,  32'sd0,        '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_INSERT,   8'd18,  -32'sd1,       '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_INSERT,   8'hAA,  32'sh55555555, '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_INSERT,   8'h55,  32'shAAAAAAAA, '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    // Decrease to a larger and to an equal priority leaves the heap alone.
    add_row(KIND_DECREASE, 8'd17,  32'sd5,        '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_DECREASE, 8'd18,  -32'sd1,       '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_DECREASE, 8'd0,   -32'sd100,     '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    // Ties must not move an entry past its equal.
    add_row(KIND_INSERT,   8'd19,  -32'sd100,     '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_DECREASE, 8'hAA,  32'sh80000000, '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_EXTRACT,  8'd0,   32'sd0,        '1, 8'd255, 32'sh80000000, STATUS_OK, '0, 9'd6);
    repeat (6) add_row(KIND_EXTRACT, 8'd0, 32'sd0, '0, 8'd0, 32'sd0, STATUS_OK, '0, 9'd0);
    add_row(KIND_EXTRACT,  8'hFF,  32'shFFFFFFFF, '1, 8'd0, 32'sd0, STATUS_EMPTY, '0, 9'd0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].kind, dir_rows[i].node, dir_rows[i].prio,
                dir_rows[i].typed, dir_rows[i].want);

    // Random phases, each started with the pipeline fully drained.
    drain_responses();
    run_phase(PHASE_MIX, 200);
    drain_responses();
    run_phase(PHASE_FILL, 150);
    drain_responses();
    run_phase(PHASE_DRAIN, 250);

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("indexed_min_heap test passed");
    end else begin
      $display("indexed_min_heap test failed");
    end
    $finish;
  end

endmodule
